>>> rtl/plm_pkg.sv
// Package with the shared types and codes of the positional list.
`default_nettype none

package plm_pkg;

    // Width of one stored entry and of the fixed port fields.
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned COUNT_W = 5;

    // Request actions.
    typedef enum logic {
        ACT_INSERT = 1'b0,
        ACT_REMOVE = 1'b1
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_BAD_POS  = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    // Removed value reported for an invalid removal.
    localparam logic signed [DATA_W-1:0] BAD_REMOVE_VALUE = '1;

    // Operation broadcast to every cell of the chain.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
    } t_cell_op;

endpackage

`default_nettype wire

>>> rtl/plm_req_if.sv
// Request channel interface: action, position and value with valid/ready.
`default_nettype none

interface plm_req_if;
    import plm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     action;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output action, output position, output value, input ready);
    modport sink   (input valid, input action, input position, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/plm_rsp_if.sv
// Response channel interface: status, removed value and count with valid/ready.
`default_nettype none

interface plm_rsp_if;
    import plm_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] removed_value;
    logic [COUNT_W-1:0]       count_after;

    modport source (output valid, output status, output removed_value, output count_after,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input count_after,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/plm_cell.sv
// One list cell: holds a single entry and shifts, loads or holds each cycle.
`default_nettype none

module plm_cell #(
    parameter int INDEX = 0
) (
    input  wire                                   i_clk,
    input  wire plm_pkg::t_cell_op                i_op,
    input  wire logic signed [plm_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [plm_pkg::DATA_W-1:0] i_right,
    output logic signed [plm_pkg::DATA_W-1:0]      o_data
);
    import plm_pkg::*;

    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;
    logic                     at_pos;
    logic                     beyond;

    // Locate this cell relative to the operation's position.
    assign at_pos = (32'(INDEX) == 32'(i_op.pos));
    assign beyond = (32'(INDEX) >  32'(i_op.pos));

    // An insert opens a gap at the position; a removal closes it.
    always_comb begin
        n_data = r_data;
        if (i_op.ins) begin
            if (at_pos) begin
                n_data = i_op.value;
            end else if (beyond) begin
                n_data = i_left;
            end
        end else if (i_op.rem) begin
            if (at_pos || beyond) begin
                n_data = i_right;
            end
        end
    end

    // The entry itself needs no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

>>> rtl/positional_list_insert_remove.sv
// Top level of the positional list: a chain of entry cells with count and result logic.
//
// Usage: requests arrive on i_req (action, position, value) and every request
// gives exactly one response on o_rsp (status, removed_value, count_after).
// An insert puts the value at the position (0 up to the count) and moves all
// later entries one place back; a removal takes out the entry at the position,
// moves later entries forward and returns the value taken out.
// Each entry lives in its own cell, and all cells shift or hold in the same
// cycle, so the response is valid in the cycle after the request transaction
// and one request is taken every cycle unless a waiting response stalls it.
// The response sits in an output register; a new request is taken while that
// register is empty or its response is taken in the same cycle, so a stalled
// receiver stalls the request channel only while a response waits.
// Reset clears the count and the response valid; the cells need no clearing,
// since only entries below the count are ever read.
// LIST_CAPACITY sets the number of cells; count_after reports the low five
// bits of the count.
`default_nettype none

module positional_list_insert_remove #(
    parameter int LIST_CAPACITY = 16
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    plm_req_if.sink   i_req,
    plm_rsp_if.source o_rsp
);
    import plm_pkg::*;

    localparam int CW = $clog2(LIST_CAPACITY + 1);
    localparam int IW = $clog2(LIST_CAPACITY);
    localparam int W  = (CW > POS_W) ? CW : POS_W;

    logic signed [DATA_W-1:0] cell_data [LIST_CAPACITY];
    t_cell_op                 op;

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            n_count;
    logic                     r_valid;
    t_status                  r_status;
    t_status                  n_status;
    logic signed [DATA_W-1:0] r_removed;
    logic signed [DATA_W-1:0] n_removed;
    logic [COUNT_W-1:0]       r_count_after;

    logic                     accept;
    logic [W-1:0]             pos_w;
    logic [W-1:0]             cnt_w;
    logic                     full;
    logic [IW-1:0]            rd_idx;

    // Request transaction handshake.
    assign i_req.ready = !r_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;

    assign pos_w  = W'(i_req.position);
    assign cnt_w  = W'(r_count);
    assign full   = (r_count == CW'(LIST_CAPACITY));
    assign rd_idx = IW'(i_req.position);

    // Decide the outcome and the new count of the request.
    always_comb begin
        op.ins    = 1'b0;
        op.rem    = 1'b0;
        op.pos    = i_req.position;
        op.value  = i_req.value;
        n_count   = r_count;
        n_status  = ST_BAD_POS;
        n_removed = '0;
        if (accept) begin
            if (t_action'(i_req.action) == ACT_INSERT) begin
                if (pos_w > cnt_w) begin
                    n_status = ST_BAD_POS;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_INSERTED;
                    op.ins   = 1'b1;
                    n_count  = r_count + CW'(1);
                end
            end else begin
                if (pos_w >= cnt_w) begin
                    n_status  = ST_BAD_POS;
                    n_removed = BAD_REMOVE_VALUE;
                end else begin
                    n_status  = ST_REMOVED;
                    n_removed = cell_data[rd_idx];
                    op.rem    = 1'b1;
                    n_count   = r_count - CW'(1);
                end
            end
        end
    end

    // Chain of cells, each linked to its neighbors.
    for (genvar g = 0; g < LIST_CAPACITY; g++) begin : g_cell
        logic signed [DATA_W-1:0] left;
        logic signed [DATA_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end

        if (g == LIST_CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end

        plm_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_op    (op),
            .i_left  (left),
            .i_right (right),
            .o_data  (cell_data[g])
        );
    end

    // Control state: count and response valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Response payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status;
            r_removed     <= n_removed;
            r_count_after <= COUNT_W'(n_count);
        end
    end

    assign o_rsp.valid         = r_valid;
    assign o_rsp.status        = r_status;
    assign o_rsp.removed_value = r_removed;
    assign o_rsp.count_after   = r_count_after;

endmodule

`default_nettype wire
